// ===== design/ccwm_pkg.sv =====
// ccwm_pkg: constants and command codes for the character class wildcard matcher
// no dependencies; used by char_class_wildcard_matcher_top
package ccwm_pkg;

    localparam int PATTERN_MAX     = 64;
    localparam int PAT_IDX_W       = $clog2(PATTERN_MAX);
    localparam int LEN_W           = 7;
    localparam int TEXT_COUNT_BITS = 16;
    localparam int ALPHABET        = 256;
    localparam int CODE_W          = $clog2(ALPHABET);
    localparam int WORDS_PER_SET   = 4;
    localparam int WORD_IDX_W      = $clog2(WORDS_PER_SET);
    localparam int SET_WORD_W      = 64;
    localparam int SET_ADDR_W      = CODE_W + WORD_IDX_W;
    localparam int SET_DEPTH       = ALPHABET * WORDS_PER_SET;
    localparam int DIFF_W          = 9;

    typedef enum logic [2:0] {
        FUNC_LOAD_WORD = 3'd0,
        FUNC_CLEAR     = 3'd1,
        FUNC_PATTERN   = 3'd2,
        FUNC_TEXT      = 3'd3,
        FUNC_COMPARE   = 3'd4
    } t_func;

endpackage

// ===== design/char_class_wildcard_matcher_top.sv =====
// char_class_wildcard_matcher_top: substring search and pair compare over wild byte classes
// one shared pair matcher (byte compare, then one expansion word pair a cycle) under a sequencer
// depends on ccwm_pkg
// set, clear and pattern commands leave busy low
// a text byte with no window check, or a compare beat, holds busy until S_FIN ends
// a text byte that checks the window passes S_RDBYTE and S_CHKBYTE for each pattern byte
// and adds S_WORD, one expansion word pair read per cycle, when the bytes differ; then S_FIN
// the result strobe is high in the first cycle with busy low; the receiver cannot stall it
// synchronous active-low reset clears control, wild marks, counters and pattern length
module char_class_wildcard_matcher_top
    import ccwm_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  i_func,
    input  logic [7:0]                  i_char_code,
    input  logic [7:0]                  i_other_code,
    input  logic [1:0]                  i_word_index,
    input  logic [63:0]                 i_mask_word,
    input  logic [5:0]                  i_slot,
    input  logic                        i_last,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [LEN_W-1:0]            i_cfg_data,
    output logic                        o_strobe,
    output logic                        o_kind,
    output logic                        o_found,
    output logic [TEXT_COUNT_BITS-1:0]  o_start_pos,
    output logic signed [DIFF_W-1:0]    o_difference
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_RDBYTE  = 5'b00010,
        S_CHKBYTE = 5'b00100,
        S_WORD    = 5'b01000,
        S_FIN     = 5'b10000
    } t_state;

    // storage
    logic [SET_WORD_W-1:0]      r_set_mem [SET_DEPTH];
    logic [CODE_W-1:0]          r_pat_mem [PATTERN_MAX];
    logic [CODE_W-1:0]          r_win_mem [PATTERN_MAX];

    logic [SET_WORD_W-1:0]      r_set_a, r_set_b;
    logic [CODE_W-1:0]          r_win_q, r_pat_q;

    t_state                     r_state, n_state;
    logic [ALPHABET-1:0]        r_wild;
    logic [LEN_W-1:0]           r_cfg_len;
    logic [LEN_W-1:0]           r_len, n_len;
    logic [TEXT_COUNT_BITS-1:0] r_count, n_count;
    logic                       r_seen, n_seen;
    logic [TEXT_COUNT_BITS-1:0] r_mstart, n_mstart;
    logic [DIFF_W-1:0]          r_diff, n_diff;
    logic                       r_last, n_last;
    logic                       r_cmp, n_cmp;
    logic [CODE_W-1:0]          r_cmp_a, n_cmp_a, r_cmp_b, n_cmp_b;
    logic [PAT_IDX_W-1:0]       r_j, n_j;
    logic [WORD_IDX_W-1:0]      r_w, n_w;
    logic [PAT_IDX_W-1:0]       r_head, n_head;
    logic [PAT_IDX_W-1:0]       r_newest, n_newest;

    logic                       r_strobe, n_strobe;
    logic                       r_kind, n_kind;
    logic                       r_found, n_found;
    logic [TEXT_COUNT_BITS-1:0] r_start, n_start;
    logic [DIFF_W-1:0]          r_diff_o, n_diff_o;

    logic                       accept;
    t_func                      func;
    logic [LEN_W-1:0]           cfg_len_clamped;
    logic [TEXT_COUNT_BITS-1:0] count_inc;
    logic [CODE_W-1:0]          op_a, op_b;
    logic [WORD_IDX_W-1:0]      rd_w;
    logic [PAT_IDX_W-1:0]       win_addr, pat_addr;
    logic [SET_WORD_W-1:0]      exp_a, exp_b;
    logic                       word_hit;
    logic                       pair_hit, pair_miss, pair_done;
    logic [DIFF_W-1:0]          pair_diff;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign func        = t_func'(i_func);

    assign cfg_len_clamped = (r_cfg_len > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : r_cfg_len;
    assign count_inc = (r_count == {TEXT_COUNT_BITS{1'b1}}) ? r_count : r_count + 1'b1;

    // operands of the shared pair matcher
    assign op_a     = r_cmp ? r_cmp_a : r_win_q;
    assign op_b     = r_cmp ? r_cmp_b : r_pat_q;
    assign rd_w     = (r_state == S_CHKBYTE) ? '0 : r_w + 1'b1;
    assign win_addr = r_newest - r_j;
    assign pat_addr = PAT_IDX_W'(r_len - 1'b1) - r_j;

    always_comb begin
        exp_a = '0;
        exp_b = '0;
        if (r_wild[op_a]) begin
            exp_a = r_set_a;
        end else if (op_a[CODE_W-1 -: WORD_IDX_W] == r_w) begin
            exp_a[op_a[CODE_W-WORD_IDX_W-1:0]] = 1'b1;
        end
        if (r_wild[op_b]) begin
            exp_b = r_set_b;
        end else if (op_b[CODE_W-1 -: WORD_IDX_W] == r_w) begin
            exp_b[op_b[CODE_W-WORD_IDX_W-1:0]] = 1'b1;
        end
    end

    assign word_hit  = |(exp_a & exp_b);
    assign pair_diff = DIFF_W'($signed({op_a[CODE_W-1], op_a}) - $signed({op_b[CODE_W-1], op_b}));

    // pair outcome from the byte check or from one expansion word pair
    always_comb begin
        pair_hit  = 1'b0;
        pair_miss = 1'b0;
        case (r_state)
            S_CHKBYTE: begin
                if (op_a == op_b) begin
                    pair_hit = 1'b1;
                end else if (!r_wild[op_a] && !r_wild[op_b]) begin
                    pair_miss = 1'b1;
                end
            end
            S_WORD: begin
                if (word_hit) begin
                    pair_hit = 1'b1;
                end else if (r_w == WORD_IDX_W'(WORDS_PER_SET - 1)) begin
                    pair_miss = 1'b1;
                end
            end
            default: begin
            end
        endcase
        pair_done = pair_hit || pair_miss;
    end

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_count  = r_count;
        n_seen   = r_seen;
        n_mstart = r_mstart;
        n_diff   = r_diff;
        n_last   = r_last;
        n_cmp    = r_cmp;
        n_cmp_a  = r_cmp_a;
        n_cmp_b  = r_cmp_b;
        n_j      = r_j;
        n_w      = r_w;
        n_head   = r_head;
        n_newest = r_newest;
        n_strobe = 1'b0;
        n_kind   = r_kind;
        n_found  = r_found;
        n_start  = r_start;
        n_diff_o = r_diff_o;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_last = i_last;
                    case (func)
                        FUNC_TEXT: begin
                            n_cmp    = 1'b0;
                            n_len    = cfg_len_clamped;
                            n_count  = count_inc;
                            n_newest = r_head;
                            n_head   = r_head + 1'b1;
                            n_j      = '0;
                            n_state  = S_FIN;
                            if (!r_seen) begin
                                if (cfg_len_clamped == '0) begin
                                    n_seen   = 1'b1;
                                    n_mstart = '0;
                                end else if (count_inc >= TEXT_COUNT_BITS'(cfg_len_clamped)) begin
                                    n_state = S_RDBYTE;
                                end
                            end
                        end
                        FUNC_COMPARE: begin
                            n_cmp   = 1'b1;
                            n_cmp_a = i_char_code;
                            n_cmp_b = i_other_code;
                            n_state = (r_diff == '0) ? S_CHKBYTE : S_FIN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RDBYTE: begin
                n_state = S_CHKBYTE;
            end
            S_CHKBYTE, S_WORD: begin
                n_w = rd_w;
                if (!pair_done) begin
                    n_state = S_WORD;
                end else if (r_cmp) begin
                    if (pair_miss) begin
                        n_diff = pair_diff;
                    end
                    n_state = S_FIN;
                end else if (pair_miss) begin
                    n_state = S_FIN;
                end else if (r_j == PAT_IDX_W'(r_len - 1'b1)) begin
                    n_seen   = 1'b1;
                    n_mstart = r_count - TEXT_COUNT_BITS'(r_len);
                    n_state  = S_FIN;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_RDBYTE;
                end
            end
            S_FIN: begin
                n_state = S_IDLE;
                if (r_last) begin
                    n_strobe = 1'b1;
                    n_kind   = r_cmp;
                    if (r_cmp) begin
                        n_found  = 1'b0;
                        n_start  = '0;
                        n_diff_o = r_diff;
                        n_diff   = '0;
                    end else begin
                        n_found  = r_seen;
                        n_start  = r_seen ? r_mstart : '0;
                        n_diff_o = '0;
                        n_count  = '0;
                        n_seen   = 1'b0;
                        n_mstart = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wild    <= '0;
            r_cfg_len <= '0;
            r_count   <= '0;
            r_seen    <= 1'b0;
            r_mstart  <= '0;
            r_diff    <= '0;
            r_head    <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_seen   <= n_seen;
            r_mstart <= n_mstart;
            r_diff   <= n_diff;
            r_head   <= n_head;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg_len <= i_cfg_data;
            end
            if (accept && func == FUNC_LOAD_WORD && i_char_code != '0) begin
                r_wild[i_char_code] <= 1'b1;
            end else if (accept && func == FUNC_CLEAR) begin
                r_wild[i_char_code] <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_last   <= n_last;
        r_cmp    <= n_cmp;
        r_cmp_a  <= n_cmp_a;
        r_cmp_b  <= n_cmp_b;
        r_j      <= n_j;
        r_w      <= n_w;
        r_newest <= n_newest;
        r_kind   <= n_kind;
        r_found  <= n_found;
        r_start  <= n_start;
        r_diff_o <= n_diff_o;
    end

    // expansion set memory, two read ports
    always_ff @(posedge i_clk) begin
        if (accept && func == FUNC_LOAD_WORD && i_char_code != '0) begin
            r_set_mem[{i_char_code, i_word_index}] <= i_mask_word;
        end
        r_set_a <= r_set_mem[{op_a, rd_w}];
        r_set_b <= r_set_mem[{op_b, rd_w}];
    end

    // pattern memory
    always_ff @(posedge i_clk) begin
        if (accept && func == FUNC_PATTERN) begin
            r_pat_mem[i_slot] <= i_char_code;
        end
        if (r_state == S_RDBYTE) begin
            r_pat_q <= r_pat_mem[pat_addr];
        end
    end

    // text window as a circular buffer
    always_ff @(posedge i_clk) begin
        if (accept && func == FUNC_TEXT) begin
            r_win_mem[r_head] <= i_char_code;
        end
        if (r_state == S_RDBYTE) begin
            r_win_q <= r_win_mem[win_addr];
        end
    end

    assign o_strobe     = r_strobe;
    assign o_kind       = r_kind;
    assign o_found      = r_found;
    assign o_start_pos  = r_start;
    assign o_difference = $signed(r_diff_o);

endmodule

// ===== tb/tb_char_class_wildcard_matcher_top.sv =====
// tb_char_class_wildcard_matcher_top: self-checking bench for the wild byte class matcher
// directed table then random phases, each result checked against a predictor held here or a value pinned in the table
// depends on ccwm_pkg and char_class_wildcard_matcher_top
`timescale 1ns / 100ps

module tb_char_class_wildcard_matcher_top
    import ccwm_pkg::*;
();

    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
    localparam int SETTLE_CYCLES  = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int POOL_N         = 12;
    localparam int NUM_PHASES     = 8;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  char_code;
        logic [7:0]  other_code;
        logic [1:0]  word_index;
        logic [63:0] mask_word;
        logic [5:0]  slot;
        logic        last;
    } t_matcher_cmd;

    typedef struct packed {
        logic                       kind;
        logic                       found;
        logic [TEXT_COUNT_BITS-1:0] start_pos;
        logic signed [DIFF_W-1:0]   difference;
    } t_match_report;

    typedef struct {
        bit            is_cfg;
        logic [LEN_W-1:0] cfg_len;
        t_matcher_cmd  cmd;
        bit            pinned;
        t_match_report rep;
    } t_plan_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [2:0]                 i_func = '0;
    logic [7:0]                 i_char_code = '0;
    logic [7:0]                 i_other_code = '0;
    logic [1:0]                 i_word_index = '0;
    logic [63:0]                i_mask_word = '0;
    logic [5:0]                 i_slot = '0;
    logic                       i_last = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [LEN_W-1:0]           i_cfg_data = '0;
    logic                       o_strobe;
    logic                       o_kind;
    logic                       o_found;
    logic [TEXT_COUNT_BITS-1:0] o_start_pos;
    logic signed [DIFF_W-1:0]   o_difference;

    // predictor state
    logic [63:0]                class_words [ALPHABET][4];
    bit                         class_wild [ALPHABET];
    logic [7:0]                 pattern_bytes [PATTERN_MAX];
    logic [7:0]                 text_hist [PATTERN_MAX];
    logic [TEXT_COUNT_BITS-1:0] text_cnt = '0;
    bit                         hit_seen = 1'b0;
    logic [TEXT_COUNT_BITS-1:0] hit_start = '0;
    logic [DIFF_W-1:0]          first_diff = '0;
    logic [LEN_W-1:0]           pattern_len_reg = '0;

    t_match_report match_reports_q [$];
    bit [3:0]      words_loaded [ALPHABET];
    logic [7:0]    alphabet_pool [POOL_N];
    int            gap_pct = 0;
    int            items_sent = 0;
    int            mismatch_count = 0;
    int            quiet_cycles = 0;

    char_class_wildcard_matcher_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_char_code  (i_char_code),
        .i_other_code (i_other_code),
        .i_word_index (i_word_index),
        .i_mask_word  (i_mask_word),
        .i_slot       (i_slot),
        .i_last       (i_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_kind       (o_kind),
        .o_found      (o_found),
        .o_start_pos  (o_start_pos),
        .o_difference (o_difference)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit classes_meet(input logic [7:0] a, input logic [7:0] b);
        logic [255:0] sa;
        logic [255:0] sb;
        if (a == b) return 1'b1;
        sa = class_wild[a] ? {class_words[a][3], class_words[a][2], class_words[a][1],
                              class_words[a][0]} : (256'd1 << a);
        sb = class_wild[b] ? {class_words[b][3], class_words[b][2], class_words[b][1],
                              class_words[b][0]} : (256'd1 << b);
        return |(sa & sb);
    endfunction

    task automatic compute_match_report(input t_matcher_cmd c, output bit has_rep,
                                        output t_match_report rep);
        int eff;
        bit ok;
        eff = (pattern_len_reg > PATTERN_MAX) ? PATTERN_MAX : int'(pattern_len_reg);
        has_rep = 1'b0;
        rep = '0;
        case (c.func)
            FUNC_LOAD_WORD: begin
                if (c.char_code != 8'd0) begin
                    class_words[c.char_code][c.word_index] = c.mask_word;
                    class_wild[c.char_code] = 1'b1;
                end
            end
            FUNC_CLEAR: class_wild[c.char_code] = 1'b0;
            FUNC_PATTERN: pattern_bytes[c.slot] = c.char_code;
            FUNC_TEXT: begin
                for (int j = PATTERN_MAX - 1; j > 0; j--) text_hist[j] = text_hist[j - 1];
                text_hist[0] = c.char_code;
                if (text_cnt != '1) text_cnt = text_cnt + 1'b1;
                if (!hit_seen) begin
                    if (eff == 0) begin
                        hit_seen = 1'b1;
                        hit_start = '0;
                    end else if (int'(text_cnt) >= eff) begin
                        ok = 1'b1;
                        for (int j = 0; j < eff; j++)
                            ok &= classes_meet(text_hist[j], pattern_bytes[eff - 1 - j]);
                        if (ok) begin
                            hit_seen = 1'b1;
                            hit_start = TEXT_COUNT_BITS'(int'(text_cnt) - eff);
                        end
                    end
                end
                if (c.last) begin
                    has_rep = 1'b1;
                    rep.found = hit_seen;
                    rep.start_pos = hit_seen ? hit_start : '0;
                    text_cnt = '0;
                    hit_seen = 1'b0;
                    hit_start = '0;
                end
            end
            FUNC_COMPARE: begin
                if (first_diff == '0 && !classes_meet(c.char_code, c.other_code))
                    first_diff = $signed({c.char_code[7], c.char_code})
                               - $signed({c.other_code[7], c.other_code});
                if (c.last) begin
                    has_rep = 1'b1;
                    rep.kind = 1'b1;
                    rep.difference = first_diff;
                    first_diff = '0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_cmd(input t_matcher_cmd c, input bit pinned,
                            input t_match_report pinned_rep);
        bit taken;
        bit has_rep;
        t_match_report rep;
        taken = 1'b0;
        i_func <= c.func;
        i_char_code <= c.char_code;
        i_other_code <= c.other_code;
        i_word_index <= c.word_index;
        i_mask_word <= c.mask_word;
        i_slot <= c.slot;
        i_last <= c.last;
        while (!taken) begin
            start <= ($urandom_range(99) >= gap_pct);
            @(posedge i_clk);
            taken = start && !busy;
        end
        items_sent++;
        if (c.func == FUNC_LOAD_WORD && c.char_code != 8'd0)
            words_loaded[c.char_code][c.word_index] = 1'b1;
        compute_match_report(c, has_rep, rep);
        if (has_rep) match_reports_q.push_back(pinned ? pinned_rep : rep);
    endtask

    task automatic write_pattern_len(input logic [LEN_W-1:0] v);
        start <= 1'b0;
        while (match_reports_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pattern_len_reg = v;
    endtask

    function automatic t_matcher_cmd op(input logic [2:0] f, input logic [7:0] code,
                                        input logic [7:0] other, input logic [1:0] w,
                                        input logic [63:0] m, input logic [5:0] s,
                                        input logic l);
        op = '{f, code, other, w, m, s, l};
    endfunction

    function automatic t_plan_row row(input t_matcher_cmd c, input bit pinned,
                                      input t_match_report r);
        row = '{1'b0, '0, c, pinned, r};
    endfunction

    function automatic t_matcher_cmd rand_cmd(input logic [2:0] f);
        t_matcher_cmd c;
        c.func = f;
        c.char_code = 8'($urandom);
        c.other_code = 8'($urandom);
        c.word_index = 2'($urandom);
        c.mask_word = {$urandom, $urandom};
        c.slot = 6'($urandom);
        c.last = 1'($urandom);
        return c;
    endfunction

    function automatic logic [7:0] pool_byte();
        return alphabet_pool[$urandom_range(POOL_N - 1)];
    endfunction

    function automatic logic [63:0] class_word(input logic [1:0] w);
        logic [63:0] m;
        case ($urandom_range(7))
            0, 1: m = {$urandom, $urandom};
            2: m = '0;
            3: m = '1;
            default: begin
                m = '0;
                for (int k = 0; k < POOL_N; k++)
                    if (alphabet_pool[k][7:6] == w && $urandom_range(1))
                        m[alphabet_pool[k][5:0]] = 1'b1;
            end
        endcase
        return m;
    endfunction

    task automatic random_episode();
        t_matcher_cmd c;
        t_matcher_cmd cp;
        logic [7:0] b;
        int pick, n, eff, at, off;
        bit plant;
        pick = $urandom_range(99);
        eff = (pattern_len_reg > PATTERN_MAX) ? PATTERN_MAX : int'(pattern_len_reg);
        if (pick < 12) begin
            // a byte turns wild with its first loaded word, so all four words are sent until each has been loaded once
            b = ($urandom_range(9) < 7) ? pool_byte() : 8'($urandom_range(255, 1));
            off = $urandom_range(3);
            n = (words_loaded[b] == 4'hf) ? $urandom_range(2, 1) : 4;
            for (int k = 0; k < n; k++) begin
                c = rand_cmd(FUNC_LOAD_WORD);
                c.char_code = b;
                c.word_index = 2'(k + off);
                c.mask_word = class_word(c.word_index);
                send_cmd(c, 1'b0, '0);
            end
        end else if (pick < 18) begin
            c = rand_cmd(FUNC_CLEAR);
            if ($urandom_range(9) < 6) c.char_code = pool_byte();
            send_cmd(c, 1'b0, '0);
        end else if (pick < 26) begin
            repeat ($urandom_range(4, 1)) begin
                c = rand_cmd(FUNC_PATTERN);
                if ($urandom_range(1)) c.char_code = pool_byte();
                send_cmd(c, 1'b0, '0);
            end
        end else if (pick < 62) begin
            n = $urandom_range(eff + 8, 1);
            plant = (n >= eff) && ($urandom_range(99) < 40);
            at = plant ? $urandom_range(n - eff, 0) : n;
            for (int k = 0; k < n; k++) begin
                c = rand_cmd(FUNC_TEXT);
                if (plant && k >= at && k < at + eff)
                    c.char_code = pattern_bytes[k - at];
                else if ($urandom_range(9) < 5)
                    c.char_code = pool_byte();
                else if ($urandom_range(9) < 8 && eff > 0)
                    c.char_code = pattern_bytes[$urandom_range(eff - 1)];
                c.last = (k == n - 1) && ($urandom_range(9) != 0);
                send_cmd(c, 1'b0, '0);
                // compare beats interleaved with an open search
                if ($urandom_range(15) == 0) begin
                    cp = rand_cmd(FUNC_COMPARE);
                    cp.other_code = cp.char_code;
                    send_cmd(cp, 1'b0, '0);
                end
            end
        end else if (pick < 94) begin
            n = $urandom_range(8, 1);
            for (int k = 0; k < n; k++) begin
                c = rand_cmd(FUNC_COMPARE);
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: begin
                        c.char_code = pool_byte();
                        c.other_code = c.char_code;
                    end
                    5, 6, 7: begin
                        c.char_code = pool_byte();
                        c.other_code = pool_byte();
                    end
                    default: ;
                endcase
                c.last = (k == n - 1) && ($urandom_range(9) != 0);
                send_cmd(c, 1'b0, '0);
            end
        end else begin
            if ($urandom_range(1)) begin
                c = rand_cmd(FUNC_LOAD_WORD);
                c.char_code = 8'd0;
            end else begin
                c = rand_cmd(3'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO)));
            end
            send_cmd(c, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        t_match_report want;
        if (i_rst_n && o_strobe) begin
            if (match_reports_q.size() == 0) begin
                report_mismatch("unexpected result", 32'({o_kind, o_found, o_start_pos}), '0);
            end else begin
                want = match_reports_q.pop_front();
                if (o_kind !== want.kind)
                    report_mismatch("kind", 32'(o_kind), 32'(want.kind));
                if (o_found !== want.found)
                    report_mismatch("found", 32'(o_found), 32'(want.found));
                if (o_start_pos !== want.start_pos)
                    report_mismatch("start_pos", 32'(o_start_pos), 32'(want.start_pos));
                if (o_difference !== want.difference)
                    report_mismatch("difference", 32'(o_difference), 32'(want.difference));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_plan_row plan [$];
        t_plan_row cfg_row;
        t_matcher_cmd c;
        int phase_len [NUM_PHASES];
        int phase_gap [NUM_PHASES];
        int phase_items [NUM_PHASES];
        int target;

        phase_len   = '{2, 5, 1, 8, 0, 64, 127, 3};
        phase_gap   = '{0, 60, 24, 0, 60, 0, 24, 60};
        phase_items = '{300, 300, 300, 280, 150, 120, 80, 300};

        // sign extremes of the compare, empty pattern
        plan.push_back(row(op(FUNC_COMPARE, 8'h7f, 8'h80, 2'd0, '0, 6'd0, 1'b1), 1'b1,
                           '{1'b1, 1'b0, 16'd0, 9'sd255}));
        plan.push_back(row(op(FUNC_COMPARE, 8'h80, 8'h7f, 2'd0, '0, 6'd0, 1'b1), 1'b1,
                           '{1'b1, 1'b0, 16'd0, -9'sd255}));
        plan.push_back(row(op(FUNC_COMPARE, 8'h00, 8'h00, 2'd0, '0, 6'd0, 1'b0), 1'b0, '0));
        plan.push_back(row(op(FUNC_COMPARE, 8'h00, 8'hff, 2'd0, '0, 6'd0, 1'b1), 1'b1,
                           '{1'b1, 1'b0, 16'd0, 9'sd1}));
        plan.push_back(row(op(FUNC_TEXT, 8'h41, 8'h00, 2'd0, '0, 6'd0, 1'b1), 1'b1,
                           '{1'b0, 1'b1, 16'd0, 9'sd0}));
        plan.push_back(row(op(FUNC_SPARE_LO, 8'hff, 8'hff, 2'd3, '1, 6'd63, 1'b1), 1'b0, '0));
        plan.push_back(row(op(FUNC_LOAD_WORD, 8'h00, 8'h00, 2'd3, '1, 6'd0, 1'b0), 1'b0, '0));
        // byte ff becomes a class that meets everything
        for (int w = 0; w < 4; w++)
            plan.push_back(row(op(FUNC_LOAD_WORD, 8'hff, 8'h00, 2'(w), '1, 6'd0, 1'b0),
                               1'b0, '0));
        // byte 61 stands for itself and 41
        for (int w = 0; w < 4; w++)
            plan.push_back(row(op(FUNC_LOAD_WORD, 8'h61, 8'h00, 2'(w),
                                  (w == 1) ? ((64'd1 << 1) | (64'd1 << 33)) : 64'd0,
                                  6'd0, 1'b0), 1'b0, '0));
        plan.push_back(row(op(FUNC_COMPARE, 8'h61, 8'h41, 2'd0, '0, 6'd0, 1'b1), 1'b0, '0));
        plan.push_back(row(op(FUNC_PATTERN, 8'h61, 8'h00, 2'd0, '0, 6'd0, 1'b0), 1'b0, '0));
        plan.push_back(row(op(FUNC_PATTERN, 8'hff, 8'h00, 2'd0, '0, 6'd1, 1'b0), 1'b0, '0));
        plan.push_back(row(op(FUNC_PATTERN, 8'h63, 8'h00, 2'd0, '0, 6'd2, 1'b0), 1'b0, '0));
        plan.push_back(row(op(FUNC_PATTERN, 8'h00, 8'h00, 2'd0, '0, 6'd63, 1'b0), 1'b0, '0));
        cfg_row = '{1'b1, 7'd3, '0, 1'b0, '0};
        plan.push_back(cfg_row);
        plan.push_back(row(op(FUNC_TEXT, 8'h78, 8'h00, 2'd0, '0, 6'd0, 1'b0), 1'b0, '0));
        plan.push_back(row(op(FUNC_TEXT, 8'h41, 8'h00, 2'd0, '0, 6'd0, 1'b0), 1'b0, '0));
        plan.push_back(row(op(FUNC_TEXT, 8'h39, 8'h00, 2'd0, '0, 6'd0, 1'b0), 1'b0, '0));
        plan.push_back(row(op(FUNC_TEXT, 8'h63, 8'h00, 2'd0, '0, 6'd0, 1'b1), 1'b0, '0));
        plan.push_back(row(op(FUNC_CLEAR, 8'h61, 8'h00, 2'd0, '0, 6'd0, 1'b0), 1'b0, '0));
        plan.push_back(row(op(FUNC_COMPARE, 8'h61, 8'h41, 2'd0, '0, 6'd0, 1'b1), 1'b0, '0));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].is_cfg)
                write_pattern_len(plan[k].cfg_len);
            else
                send_cmd(plan[k].cmd, plan[k].pinned, plan[k].rep);
        end

        foreach (alphabet_pool[k]) alphabet_pool[k] = 8'($urandom);
        for (int s = 0; s < PATTERN_MAX; s++) begin
            c = rand_cmd(FUNC_PATTERN);
            c.slot = 6'(s);
            if ($urandom_range(1)) c.char_code = pool_byte();
            send_cmd(c, 1'b0, '0);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_pattern_len(7'(phase_len[p]));
            gap_pct = phase_gap[p];
            foreach (alphabet_pool[k])
                if ($urandom_range(2) == 0) alphabet_pool[k] = 8'($urandom);
            target = items_sent + phase_items[p];
            while (items_sent < target) random_episode();
        end

        start <= 1'b0;
        while (match_reports_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
